/* rtl/assert_macros.svh */
// Assertion macros used by the leaky bucket admission core (lba_core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge, skipped while reset is high.
`define LBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lba assertion failed");
// Property checked on every rising clock edge, reset included.
`define LBA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("lba assertion failed");
`else
`define LBA_ASSERT(lbl, clk, rst, prop)
`define LBA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/lba_pkg.sv */
// Types and constants of the leaky bucket admission block.
`default_nettype none

package lba_pkg;

   // Field and state widths.
   localparam int DATA_WIDTH  = 32;
   localparam int LEVEL_WIDTH = 32;
   localparam int SUM_WIDTH   = ((LEVEL_WIDTH > DATA_WIDTH) ? LEVEL_WIDTH : DATA_WIDTH) + 1;
   localparam int CSR_INDEX_WIDTH = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BUCKET_VOLUME = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEAK_AMOUNT   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HIGH_MARK     = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOW_MARK      = 2'd3;

   // Register reset values.
   localparam logic [DATA_WIDTH-1:0] VOLUME_RESET = 32'd1024;
   localparam logic [DATA_WIDTH-1:0] LEAK_RESET   = 32'd64;
   localparam logic [DATA_WIDTH-1:0] MARK_RESET   = 32'd0;

   // Request kinds.
   localparam logic REQ_FILL = 1'b0;
   localparam logic REQ_LEAK = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ACCEPT   = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_WAIT     = 2'd2,
      STATUS_LEAK     = 2'd3
   } status_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] bucket_volume;
      logic [DATA_WIDTH-1:0] leak_amount;
      logic [DATA_WIDTH-1:0] high_mark;
      logic [DATA_WIDTH-1:0] low_mark;
   } cfg_type;

   typedef struct packed {
      logic                  req_type;
      logic [DATA_WIDTH-1:0] amount;
      logic                  blocking;
   } req_item_type;

   typedef struct packed {
      status_type            status;
      logic                  high_delay;
      logic                  low_delay;
      logic [DATA_WIDTH-1:0] fill_level;
   } rsp_item_type;

endpackage

`default_nettype wire

/* rtl/lba_if.sv */
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface lba_req_if;
   logic                            valid;
   logic                            ready;
   logic                            req_type;
   logic [lba_pkg::DATA_WIDTH-1:0]  amount;
   logic                            blocking;

   modport source (output valid, output req_type, output amount, output blocking,
                   input ready);
   modport sink (input valid, input req_type, input amount, input blocking,
                 output ready);
endinterface

interface lba_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      status;
   logic                            high_delay;
   logic                            low_delay;
   logic [lba_pkg::DATA_WIDTH-1:0]  fill_level;

   modport source (output valid, output status, output high_delay, output low_delay,
                   output fill_level, input ready);
   modport sink (input valid, input status, input high_delay, input low_delay,
                 input fill_level, output ready);
endinterface

`default_nettype wire

/* rtl/lba_csr.sv */
// Configuration register file of the leaky bucket admission block.
`default_nettype none

module lba_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [lba_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [lba_pkg::DATA_WIDTH-1:0]       csr_wr_data,
   output lba_pkg::cfg_type                          cfg
);

   lba_pkg::cfg_type cfg_ff;
   lba_pkg::cfg_type cfg_in;

   // Decode the write index into one register update.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lba_pkg::CSR_BUCKET_VOLUME: cfg_in.bucket_volume = csr_wr_data;
            lba_pkg::CSR_LEAK_AMOUNT:   cfg_in.leak_amount   = csr_wr_data;
            lba_pkg::CSR_HIGH_MARK:     cfg_in.high_mark     = csr_wr_data;
            lba_pkg::CSR_LOW_MARK:      cfg_in.low_mark      = csr_wr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bucket_volume <= lba_pkg::VOLUME_RESET;
         cfg_ff.leak_amount   <= lba_pkg::LEAK_RESET;
         cfg_ff.high_mark     <= lba_pkg::MARK_RESET;
         cfg_ff.low_mark      <= lba_pkg::MARK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/lba_core.sv */
// Bucket state and the per-beat admission decision.
`default_nettype none
`include "assert_macros.svh"

module lba_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire lba_pkg::req_item_type item,
   input  wire lba_pkg::cfg_type      cfg,
   output lba_pkg::rsp_item_type      result
);

   logic [lba_pkg::LEVEL_WIDTH-1:0] level_ff;
   logic [lba_pkg::LEVEL_WIDTH-1:0] level_in;
   logic                            high_hit_ff;
   logic                            high_hit_in;
   logic                            low_hit_ff;
   logic                            low_hit_in;

   logic [lba_pkg::DATA_WIDTH-1:0]  amount_clamped;
   logic [lba_pkg::DATA_WIDTH-1:0]  high_eff;
   logic [lba_pkg::DATA_WIDTH-1:0]  low_eff;
   logic [lba_pkg::DATA_WIDTH-1:0]  drain;
   logic [lba_pkg::SUM_WIDTH-1:0]   level_ext;
   logic [lba_pkg::SUM_WIDTH-1:0]   sum;
   logic [lba_pkg::SUM_WIDTH-1:0]   leak_diff;
   logic [lba_pkg::SUM_WIDTH-1:0]   level_max_ext;
   logic [lba_pkg::SUM_WIDTH-1:0]   out_level_ext;
   logic [lba_pkg::LEVEL_WIDTH-1:0] fill_level_sat;
   logic [lba_pkg::LEVEL_WIDTH-1:0] leak_level;
   logic                            high_cross;
   logic                            low_cross;
   logic                            over_volume;

   // Operand preparation: clamp the amount and order the watermarks.
   always_comb begin
      amount_clamped = (item.amount > cfg.bucket_volume) ? cfg.bucket_volume : item.amount;
      if (cfg.low_mark > cfg.high_mark) begin
         high_eff = cfg.low_mark;
         low_eff  = cfg.low_mark >> 1;
      end else begin
         high_eff = cfg.high_mark;
         low_eff  = cfg.low_mark;
      end
      drain = (cfg.leak_amount < cfg.bucket_volume) ? cfg.leak_amount : cfg.bucket_volume;
   end

   assign level_ext = {{(lba_pkg::SUM_WIDTH - lba_pkg::LEVEL_WIDTH){1'b0}}, level_ff};
   assign sum = level_ext
              + {{(lba_pkg::SUM_WIDTH - lba_pkg::DATA_WIDTH){1'b0}}, amount_clamped};
   assign leak_diff = level_ext
                    - {{(lba_pkg::SUM_WIDTH - lba_pkg::DATA_WIDTH){1'b0}}, drain};
   assign level_max_ext = {{(lba_pkg::SUM_WIDTH - lba_pkg::LEVEL_WIDTH){1'b0}},
                           {lba_pkg::LEVEL_WIDTH{1'b1}}};

   // Watermark and capacity comparisons on the widened sum.
   assign high_cross = !high_hit_ff && (high_eff != '0)
                     && (sum > {{(lba_pkg::SUM_WIDTH - lba_pkg::DATA_WIDTH){1'b0}}, high_eff});
   assign low_cross  = !low_hit_ff && (low_eff != '0)
                     && (sum > {{(lba_pkg::SUM_WIDTH - lba_pkg::DATA_WIDTH){1'b0}}, low_eff});
   assign over_volume = sum > {{(lba_pkg::SUM_WIDTH - lba_pkg::DATA_WIDTH){1'b0}},
                               cfg.bucket_volume};

   // An accepted sum beyond the level range sticks at the top value.
   assign fill_level_sat = (sum > level_max_ext) ? {lba_pkg::LEVEL_WIDTH{1'b1}}
                                                 : sum[lba_pkg::LEVEL_WIDTH-1:0];
   // A leak floors at zero.
   assign leak_level = (level_ext > {{(lba_pkg::SUM_WIDTH - lba_pkg::DATA_WIDTH){1'b0}}, drain})
                     ? leak_diff[lba_pkg::LEVEL_WIDTH-1:0] : '0;

   // Next state and the response of the current beat.
   always_comb begin
      level_in          = level_ff;
      high_hit_in       = high_hit_ff;
      low_hit_in        = low_hit_ff;
      result.high_delay = 1'b0;
      result.low_delay  = 1'b0;
      if (item.req_type == lba_pkg::REQ_LEAK) begin
         level_in      = leak_level;
         high_hit_in   = 1'b0;
         low_hit_in    = 1'b0;
         result.status = lba_pkg::STATUS_LEAK;
      end else begin
         if (high_cross) begin
            high_hit_in       = 1'b1;
            result.high_delay = 1'b1;
         end
         if (low_cross) begin
            low_hit_in       = 1'b1;
            result.low_delay = 1'b1;
         end
         if (over_volume) begin
            result.status = item.blocking ? lba_pkg::STATUS_WAIT : lba_pkg::STATUS_NO_SPACE;
         end else begin
            level_in      = fill_level_sat;
            result.status = lba_pkg::STATUS_ACCEPT;
         end
      end
      out_level_ext     = {{(lba_pkg::SUM_WIDTH - lba_pkg::LEVEL_WIDTH){1'b0}}, level_in};
      result.fill_level = out_level_ext[lba_pkg::DATA_WIDTH-1:0];
   end

   // State moves only when the beat leaves for the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= '0;
         high_hit_ff <= 1'b0;
         low_hit_ff  <= 1'b0;
      end else if (advance) begin
         level_ff    <= level_in;
         high_hit_ff <= high_hit_in;
         low_hit_ff  <= low_hit_in;
      end
   end

   // A leak re-arms both watermarks.
   `LBA_ASSERT(a_leak_rearms, clock, reset,
      (advance && item.req_type == lba_pkg::REQ_LEAK) |=> (!high_hit_ff && !low_hit_ff))
   // A leak never raises the level.
   `LBA_ASSERT(a_leak_no_rise, clock, reset,
      (advance && item.req_type == lba_pkg::REQ_LEAK) |=> (level_ff <= $past(level_ff)))
   // A refused fill leaves the level alone.
   `LBA_ASSERT(a_refused_keeps_level, clock, reset,
      (advance && item.req_type == lba_pkg::REQ_FILL && over_volume) |=> $stable(level_ff))
   // A stall leaves the whole state alone.
   `LBA_ASSERT(a_stall_holds_state, clock, reset,
      !advance |=> ($stable(level_ff) && $stable(high_hit_ff) && $stable(low_hit_ff)))

endmodule

`default_nettype wire

/* rtl/leaky_bucket_admission_core.sv */
// Leaky bucket admission core: request register, decision logic, response register.
// A request waits in the request register while it is decided, and its response is
// registered in the response register. Throughput: one request per cycle unless
// responses stall; the level add and compare are combinational.
// Reset (synchronous, active high) empties both registers, clears level and
// watermark flags, and loads the configuration reset values.
`default_nettype none

module leaky_bucket_admission_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   lba_req_if.sink                                   req_bus,
   lba_rsp_if.source                                 rsp_bus,
   input  wire logic                                 csr_wr_en,
   input  wire logic [lba_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [lba_pkg::DATA_WIDTH-1:0]       csr_wr_data
);

   lba_pkg::cfg_type      cfg;
   lba_pkg::req_item_type req_item;
   lba_pkg::rsp_item_type core_result;

   logic                  req_valid_ff;
   logic                  req_valid_in;
   lba_pkg::req_item_type req_item_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   lba_pkg::rsp_item_type rsp_item_ff;
   logic                  advance;
   logic                  req_take;

   lba_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   lba_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   // The held beat moves on when the response register is free or being emptied.
   assign advance = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;
   assign req_take = req_bus.valid && req_bus.ready;

   assign req_item.req_type = req_bus.req_type;
   assign req_item.amount   = req_bus.amount;
   assign req_item.blocking = req_bus.blocking;

   // Occupancy of the two registers.
   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_item_ff.status;
   assign rsp_bus.high_delay = rsp_item_ff.high_delay;
   assign rsp_bus.low_delay  = rsp_item_ff.low_delay;
   assign rsp_bus.fill_level = rsp_item_ff.fill_level;

endmodule

`default_nettype wire

/* bench/lba_admission_checker.sv */
// Checker for the leaky bucket admission core: predicts every decision and compares response beats.
`timescale 1ns / 1ps

module lba_admission_checker
   import lba_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   lba_req_if                              req_mon,
   lba_rsp_if                              rsp_mon,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [DATA_WIDTH-1:0]      csr_wr_data,
   output int                              decisions_pending,
   output int                              mismatch_count
);

   // Largest value the level register can hold.
   localparam logic [63:0] LEVEL_CEILING = (64'd1 << LEVEL_WIDTH) - 64'd1;

   cfg_type      bucket_cfg;
   logic [63:0]  bucket_level;
   logic         high_tripped;
   logic         low_tripped;
   rsp_item_type decision_queue[$];

   // Works out the response to one request and advances the bucket state.
   task automatic decide_admission(input logic kind, input logic [DATA_WIDTH-1:0] units,
                                   input logic wait_on_full, output rsp_item_type verdict);
      logic [63:0] drain;
      logic [63:0] clamped;
      logic [63:0] high_eff;
      logic [63:0] low_eff;
      logic [63:0] sum;
      verdict = '0;
      if (kind == REQ_LEAK) begin
         // A leak drains at most the volume, floors at zero and re-arms both marks.
         drain = (bucket_cfg.leak_amount < bucket_cfg.bucket_volume) ?
                 64'(bucket_cfg.leak_amount) : 64'(bucket_cfg.bucket_volume);
         bucket_level = (bucket_level > drain) ? bucket_level - drain : 64'd0;
         high_tripped = 1'b0;
         low_tripped = 1'b0;
         verdict.status = STATUS_LEAK;
      end else begin
         // An oversized fill counts only as much as the volume.
         clamped = (units > bucket_cfg.bucket_volume) ?
                   64'(bucket_cfg.bucket_volume) : 64'(units);
         high_eff = 64'(bucket_cfg.high_mark);
         low_eff = 64'(bucket_cfg.low_mark);
         // Marks out of order: the low mark becomes the high one, and half of it the low one.
         if (low_eff > high_eff) begin
            high_eff = low_eff;
            low_eff = low_eff >> 1;
         end
         sum = bucket_level + clamped;
         // Soft marks fire once each, before the hard capacity check.
         if (!high_tripped && high_eff != 0 && sum > high_eff) begin
            high_tripped = 1'b1;
            verdict.high_delay = 1'b1;
         end
         if (!low_tripped && low_eff != 0 && sum > low_eff) begin
            low_tripped = 1'b1;
            verdict.low_delay = 1'b1;
         end
         if (sum > bucket_cfg.bucket_volume) begin
            verdict.status = wait_on_full ? STATUS_WAIT : STATUS_NO_SPACE;
         end else begin
            bucket_level = (sum > LEVEL_CEILING) ? LEVEL_CEILING : sum;
            verdict.status = STATUS_ACCEPT;
         end
      end
      verdict.fill_level = bucket_level[DATA_WIDTH-1:0];
   endtask

   // Reports one field that differs from its prediction.
   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_count = mismatch_count + 1;
      end
   endtask

   // All sampling happens on the rising edge, before any of this edge's updates land.
   always @(posedge clock) begin
      rsp_item_type verdict;
      if (reset) begin
         bucket_cfg = '{bucket_volume: VOLUME_RESET, leak_amount: LEAK_RESET,
                        high_mark: MARK_RESET, low_mark: MARK_RESET};
         bucket_level = '0;
         high_tripped = 1'b0;
         low_tripped = 1'b0;
         decision_queue.delete();
         mismatch_count = 0;
      end else begin
         // Response beats are matched in order against the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (decision_queue.size() == 0) begin
               $display("%0t: response beat with nothing expected, actual status %0d level %0h",
                        $time, rsp_mon.status, rsp_mon.fill_level);
               mismatch_count = mismatch_count + 1;
            end else begin
               verdict = decision_queue.pop_front();
               compare_field("status", 64'(verdict.status), 64'(rsp_mon.status));
               compare_field("high_delay", 64'(verdict.high_delay), 64'(rsp_mon.high_delay));
               compare_field("low_delay", 64'(verdict.low_delay), 64'(rsp_mon.low_delay));
               compare_field("fill_level", 64'(verdict.fill_level), 64'(rsp_mon.fill_level));
            end
         end

         // Register writes take effect before a request taken on the same edge is decided.
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BUCKET_VOLUME: bucket_cfg.bucket_volume = csr_wr_data;
               CSR_LEAK_AMOUNT:   bucket_cfg.leak_amount = csr_wr_data;
               CSR_HIGH_MARK:     bucket_cfg.high_mark = csr_wr_data;
               CSR_LOW_MARK:      bucket_cfg.low_mark = csr_wr_data;
               default: ;
            endcase
         end

         // Every request beat is answered by exactly one response beat.
         if (req_mon.valid && req_mon.ready) begin
            decide_admission(req_mon.req_type, req_mon.amount, req_mon.blocking, verdict);
            decision_queue.push_back(verdict);
         end
      end
      decisions_pending <= decision_queue.size();
   end

endmodule

/* bench/leaky_bucket_admission_core_tb.sv */
// Testbench top for the leaky bucket admission core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module leaky_bucket_admission_core_tb;
   import lba_pkg::*;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [DATA_WIDTH-1:0]      csr_wr_data;
   int                         decisions_pending;
   int                         mismatch_count;
   logic [63:0]                volume_now;
   bit                         feed_steady;
   bit                         drain_steady;

   lba_req_if req_bus();
   lba_rsp_if rsp_bus();

   leaky_bucket_admission_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   lba_admission_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .decisions_pending (decisions_pending),
      .mismatch_count    (mismatch_count)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard stop in case the handshakes hang.
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Stops sending and waits until every request has been answered.
   task automatic await_quiet();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (decisions_pending != 0);
   endtask

   // Loads all four registers once the core has gone idle.
   task automatic program_bucket(input logic [DATA_WIDTH-1:0] volume,
                                 input logic [DATA_WIDTH-1:0] leak,
                                 input logic [DATA_WIDTH-1:0] hi_mark,
                                 input logic [DATA_WIDTH-1:0] lo_mark);
      await_quiet();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BUCKET_VOLUME;
      csr_wr_data <= volume;
      @(posedge clock);
      csr_index <= CSR_LEAK_AMOUNT;
      csr_wr_data <= leak;
      @(posedge clock);
      csr_index <= CSR_HIGH_MARK;
      csr_wr_data <= hi_mark;
      @(posedge clock);
      csr_index <= CSR_LOW_MARK;
      csr_wr_data <= lo_mark;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      volume_now = 64'(volume);
   endtask

   // Presents one request beat after a random gap (none while feed_steady is set) and holds it until taken.
   task automatic send_request(input logic kind, input logic [DATA_WIDTH-1:0] units,
                               input logic wait_on_full);
      int gap;
      gap = feed_steady ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.amount <= units;
      req_bus.blocking <= wait_on_full;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Response side: random stalls per beat, with stretches of none.
   initial begin
      int gap;
      int beats;
      rsp_bus.ready = 1'b0;
      beats = 0;
      forever begin
         if (beats % 32 == 0) drain_steady = ($urandom_range(0, 3) == 0);
         gap = drain_steady ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         beats++;
      end
   end

   // Stimulus: reset, directed cases, then random phases under varied settings.
   initial begin
      logic [63:0]           span;
      logic [DATA_WIDTH-1:0] units;
      logic [DATA_WIDTH-1:0] vol;
      logic [DATA_WIDTH-1:0] leak;
      logic [DATA_WIDTH-1:0] hi_mark;
      logic [DATA_WIDTH-1:0] lo_mark;
      int                    phase;
      int                    n;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_FILL;
      req_bus.amount = '0;
      req_bus.blocking = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_BUCKET_VOLUME;
      csr_wr_data = '0;
      volume_now = 64'(VOLUME_RESET);
      feed_steady = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: empty fill, both refusals, oversized fill, leak with junk, exact fit.
      send_request(REQ_FILL, 32'd0, 1'b0);
      send_request(REQ_FILL, 32'd1000, 1'b0);
      send_request(REQ_FILL, 32'd100, 1'b0);
      send_request(REQ_FILL, 32'd100, 1'b1);
      send_request(REQ_FILL, 32'hFFFF_FFFF, 1'b1);
      send_request(REQ_LEAK, 32'hFFFF_FFFF, 1'b1);
      send_request(REQ_FILL, 32'd24, 1'b0);
      send_request(REQ_FILL, 32'd64, 1'b1);

      // Ordered marks and a leak larger than the volume.
      program_bucket(32'd1024, 32'd2000, 32'd600, 32'd300);
      send_request(REQ_LEAK, 32'd0, 1'b0);
      send_request(REQ_FILL, 32'd400, 1'b0);
      send_request(REQ_FILL, 32'd300, 1'b0);
      send_request(REQ_FILL, 32'd1, 1'b1);
      send_request(REQ_FILL, 32'd400, 1'b1);
      send_request(REQ_LEAK, 32'd5, 1'b0);
      send_request(REQ_FILL, 32'd1000, 1'b0);

      // Marks out of order, and a refused fill that still trips both marks.
      program_bucket(32'd1024, 32'd100, 32'd100, 32'd800);
      send_request(REQ_FILL, 32'd900, 1'b0);
      send_request(REQ_LEAK, 32'd0, 1'b1);
      send_request(REQ_FILL, 32'd300, 1'b0);
      send_request(REQ_FILL, 32'd1, 1'b0);

      // Zero volume, then a volume below the current level.
      program_bucket(32'd0, 32'd64, 32'd0, 32'd0);
      send_request(REQ_FILL, 32'd0, 1'b0);
      send_request(REQ_LEAK, 32'd0, 1'b0);
      program_bucket(32'd500, 32'd300, 32'd0, 32'd0);
      send_request(REQ_FILL, 32'd0, 1'b1);
      send_request(REQ_LEAK, 32'd0, 1'b0);
      send_request(REQ_LEAK, 32'd0, 1'b0);
      send_request(REQ_FILL, 32'd299, 1'b0);

      // Random phases; the first two use the register extremes.
      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0: program_bucket(32'd1, 32'd1, MARK_RESET, MARK_RESET);
            1: program_bucket('1, '1, '1, '1);
            default: begin
               case ($urandom_range(0, 3))
                  0: vol = $urandom_range(1, 16);
                  1: vol = $urandom_range(100, 5000);
                  2: vol = $urandom();
                  default: vol = '1;
               endcase
               leak = ($urandom_range(0, 4) == 0) ? '1 : $urandom_range(1, vol / 2 + 1);
               hi_mark = ($urandom_range(0, 2) == 0) ? '0 : $urandom_range(0, vol);
               lo_mark = ($urandom_range(0, 2) == 0) ? '0 : $urandom_range(0, vol);
               program_bucket(vol, leak, hi_mark, lo_mark);
            end
         endcase
         feed_steady = ($urandom_range(0, 2) == 0);
         for (n = 0; n < 90; n++) begin
            // Mostly amounts that fit in a few steps, some full-width and boundary ones.
            span = volume_now / 3 + 1;
            case ($urandom_range(0, 9))
               0: units = $urandom();
               1: units = ($urandom_range(0, 1) != 0) ? '1 : '0;
               2: units = volume_now[DATA_WIDTH-1:0];
               default: units = $urandom_range(0, span[DATA_WIDTH-1:0]);
            endcase
            send_request(($urandom_range(0, 3) == 0) ? REQ_LEAK : REQ_FILL, units,
                         1'($urandom_range(0, 1)));
         end
      end

      await_quiet();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
